// ===== design/wbpc_pkg.sv =====
package wbpc_pkg;

  localparam int CHAN_W = 8;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;
  localparam int LEVEL_W = 17;
  localparam int LEVEL_FRAC_BITS = 16;
  localparam int ROW_W = 11;
  localparam int MAX_ROWS = 2048;
  localparam int ROWS_W = $clog2(MAX_ROWS + 1);
  localparam int HALF_W = ROWS_W - 1;
  localparam int CMP_W = ((ROW_W > ROWS_W) ? ROW_W : ROWS_W) + 1;
  localparam int PROD_W = LEVEL_W + HALF_W;

  // Rounded-up reciprocal of 255 scaled by 2^32, exact for 24-bit dividends.
  localparam logic [24:0] RECIP_255 = 25'd16843010;

  typedef struct packed {
    logic [CHAN_W-1:0] a;
    logic [2:0][CHAN_W-1:0] rgb;
  } argb_t;

  typedef enum logic [2:0] {
    CFG_STRIP_ROWS       = 3'd0,
    CFG_COLOR_BACKGROUND = 3'd1,
    CFG_COLOR_UNPLAYED   = 3'd2,
    CFG_COLOR_PLAYED     = 3'd3,
    CFG_COLOR_PLAYHEAD   = 3'd4
  } cfg_reg_t;

  function automatic logic [15:0] div255(logic [23:0] x);
    logic [48:0] p;
    p = 49'(x) * 49'(RECIP_255);
    return p[47:32];
  endfunction

endpackage

// ===== design/wbpc_over.sv =====
module wbpc_over import wbpc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  argb_t in_bg,
  input  argb_t in_fg,
  input  logic  in_aux,
  output logic  out_valid,
  input  logic  out_ready,
  output argb_t out_pix,
  output logic  out_aux
);

  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES = CHAN_W / BITS_PER_STAGE;
  localparam int NS = 4 + DIV_STAGES;
  localparam int NUM_W = 2 * CHAN_W + 1;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [CHAN_W-1:0] quot;
  } rq_t;

  typedef struct packed {
    argb_t fg;
    argb_t bg;
    logic aux;
    logic [15:0] t;
    logic [2:0][15:0] fa;
  } s1_t;

  typedef struct packed {
    argb_t fg;
    argb_t bg;
    logic aux;
    logic [2:0][23:0] p;
    logic [2:0][15:0] fa;
    logic [CHAN_W-1:0] t255;
  } s2_t;

  typedef struct packed {
    argb_t fg;
    argb_t bg;
    logic aux;
    logic [2:0][15:0] fa;
    logic [2:0][15:0] q;
    logic [CHAN_W-1:0] oa;
  } s3_t;

  typedef struct packed {
    argb_t fg;
    argb_t bg;
    logic aux;
    logic [2:0][NUM_W-1:0] num;
    logic [CHAN_W-1:0] oa;
  } s4_t;

  typedef struct packed {
    argb_t fg;
    argb_t bg;
    logic aux;
    logic [CHAN_W-1:0] oa;
    logic [2:0] sat;
    rq_t [2:0] rq;
  } dv_t;

  function automatic rq_t div_bit(rq_t x, logic [CHAN_W-1:0] d, logic [2:0] sh);
    logic [NUM_W-1:0] dd;
    rq_t y;
    dd = NUM_W'(d) << sh;
    y = x;
    if (x.rem >= dd) begin
      y.rem = x.rem - dd;
      y.quot[sh] = 1'b1;
    end
    return y;
  endfunction

  logic [NS-1:0] v;
  logic [NS-1:0] ld;
  logic [NS-1:0] v_src;

  s1_t s1, s1_next;
  s2_t s2, s2_next;
  s3_t s3, s3_next;
  s4_t s4, s4_next;
  dv_t d [DIV_STAGES];
  dv_t d_src [DIV_STAGES];
  dv_t d_next [DIV_STAGES];
  dv_t last;
  logic [CHAN_W:0] oa_sum;

  always_comb begin
    ld[NS-1] = !v[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  assign v_src = {v[NS-2:0], in_valid};
  assign in_ready = ld[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (ld[k]) begin
          v[k] <= v_src[k];
        end
      end
    end
  end

  always_comb begin
    s1_next.fg = in_fg;
    s1_next.bg = in_bg;
    s1_next.aux = in_aux;
    s1_next.t = 16'(in_bg.a) * 16'(CHAN_MAX - in_fg.a);
    for (int c = 0; c < 3; c++) begin
      s1_next.fa[c] = 16'(in_fg.rgb[c]) * 16'(in_fg.a);
    end
  end

  always_comb begin
    s2_next.fg = s1.fg;
    s2_next.bg = s1.bg;
    s2_next.aux = s1.aux;
    s2_next.fa = s1.fa;
    s2_next.t255 = CHAN_W'(div255(24'(s1.t)));
    for (int c = 0; c < 3; c++) begin
      s2_next.p[c] = 24'(s1.bg.rgb[c]) * 24'(s1.t);
    end
  end

  always_comb begin
    s3_next.fg = s2.fg;
    s3_next.bg = s2.bg;
    s3_next.aux = s2.aux;
    s3_next.fa = s2.fa;
    for (int c = 0; c < 3; c++) begin
      s3_next.q[c] = div255(s2.p[c]);
    end
    oa_sum = (CHAN_W + 1)'(s2.fg.a) + (CHAN_W + 1)'(s2.t255);
    s3_next.oa = (oa_sum > (CHAN_W + 1)'(CHAN_MAX)) ? CHAN_MAX : oa_sum[CHAN_W-1:0];
  end

  always_comb begin
    s4_next.fg = s3.fg;
    s4_next.bg = s3.bg;
    s4_next.aux = s3.aux;
    s4_next.oa = s3.oa;
    for (int c = 0; c < 3; c++) begin
      s4_next.num[c] = NUM_W'(s3.fa[c]) + NUM_W'(s3.q[c]);
    end
  end

  always_comb begin
    d_src[0].fg = s4.fg;
    d_src[0].bg = s4.bg;
    d_src[0].aux = s4.aux;
    d_src[0].oa = s4.oa;
    for (int c = 0; c < 3; c++) begin
      d_src[0].sat[c] = s4.num[c] >= {1'b0, s4.oa, {CHAN_W{1'b0}}};
      d_src[0].rq[c].rem = s4.num[c];
      d_src[0].rq[c].quot = '0;
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      d_src[k] = d[k-1];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      d_next[k] = d_src[k];
      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < BITS_PER_STAGE; j++) begin
          d_next[k].rq[c] = div_bit(d_next[k].rq[c], d_src[k].oa,
                                    3'(CHAN_W - 1 - BITS_PER_STAGE * k - j));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1 <= s1_next;
    end
    if (ld[1]) begin
      s2 <= s2_next;
    end
    if (ld[2]) begin
      s3 <= s3_next;
    end
    if (ld[3]) begin
      s4 <= s4_next;
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (ld[4+k]) begin
        d[k] <= d_next[k];
      end
    end
  end

  assign last = d[DIV_STAGES-1];
  assign out_aux = last.aux;

  always_comb begin
    if (last.fg.a == CHAN_MAX) begin
      out_pix = last.fg;
    end else if (last.fg.a == '0) begin
      out_pix = last.bg;
    end else begin
      out_pix.a = last.oa;
      for (int c = 0; c < 3; c++) begin
        out_pix.rgb[c] = last.sat[c] ? CHAN_MAX : last.rq[c].quot;
      end
    end
  end

endmodule

// ===== design/waveform_bar_pixel_compositor.sv =====
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
// item      in         item_valid/item_stall  row, level, played, on_playhead
// pixel     out        pixel_valid/pixel_stall pixel
//
// One pixel is taken every cycle while the output does not stall; each pixel passes two
// front stages and two eight-stage blend pipelines, each with a four-stage division by the
// output alpha.
// Reset clears the pipeline valid bits and loads the register reset values.
// A stall on the output holds the last stage; bubbles ahead of it close up before the
// input is stalled.
module waveform_bar_pixel_compositor import wbpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [ROW_W-1:0]   row,
  input  logic [LEVEL_W-1:0] level,
  input  logic               played,
  input  logic               on_playhead,
  output logic               pixel_valid,
  input  logic               pixel_stall,
  output logic [31:0]        pixel
);

  localparam logic [LEVEL_W-1:0] FULL = LEVEL_W'(1 << LEVEL_FRAC_BITS);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [ROWS_W-1:0] rows;
    logic [HALF_W-1:0] half;
    logic [PROD_W-1:0] prod;
    logic played;
    logic head;
  } f1_t;

  typedef struct packed {
    argb_t fg;
    logic aux;
  } f2_t;

  logic [ROW_W-1:0] strip_rows;
  argb_t color_background;
  argb_t color_unplayed;
  argb_t color_played;
  argb_t color_playhead;

  f1_t f1, f1_next;
  f2_t f2, f2_next;
  logic v_f1, v_f2, ld_f1, ld_f2;
  logic [LEVEL_W-1:0] level_c;
  logic [CMP_W-1:0] bar, row_x, half_x;
  logic in_strip, in_bar;

  logic o1_ready, o1_valid, o1_aux, o2_ready, o2_valid;
  argb_t o1_pix, o2_fg, o2_pix;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_rows <= ROW_W'(20);
      color_background <= '0;
      color_unplayed <= '0;
      color_played <= '0;
      color_playhead <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_STRIP_ROWS:       strip_rows <= cfg_data[ROW_W-1:0];
        CFG_COLOR_BACKGROUND: color_background <= cfg_data;
        CFG_COLOR_UNPLAYED:   color_unplayed <= cfg_data;
        CFG_COLOR_PLAYED:     color_played <= cfg_data;
        CFG_COLOR_PLAYHEAD:   color_playhead <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ld_f2 = !v_f2 || o1_ready;
  assign ld_f1 = !v_f1 || ld_f2;
  assign item_stall = !ld_f1;

  always_comb begin
    f1_next.row = row;
    f1_next.played = played;
    f1_next.head = on_playhead;
    if (32'(strip_rows) > MAX_ROWS) begin
      f1_next.rows = ROWS_W'(MAX_ROWS);
    end else begin
      f1_next.rows = ROWS_W'(strip_rows);
    end
    f1_next.half = HALF_W'(f1_next.rows >> 1);
    level_c = (level > FULL) ? FULL : level;
    f1_next.prod = PROD_W'(level_c) * PROD_W'(f1_next.half);
  end

  always_comb begin
    bar = CMP_W'(f1.prod >> LEVEL_FRAC_BITS);
    row_x = CMP_W'(f1.row);
    half_x = CMP_W'(f1.half);
    in_strip = row_x < CMP_W'(f1.rows);
    in_bar = (row_x + bar >= half_x) && (row_x < half_x + bar);
    if (in_strip && in_bar) begin
      f2_next.fg = f1.played ? color_played : color_unplayed;
    end else begin
      f2_next.fg = '0;
    end
    f2_next.aux = in_strip && f1.head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_f1 <= 1'b0;
      v_f2 <= 1'b0;
    end else begin
      if (ld_f1) begin
        v_f1 <= item_valid;
      end
      if (ld_f2) begin
        v_f2 <= v_f1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_f1) begin
      f1 <= f1_next;
    end
    if (ld_f2) begin
      f2 <= f2_next;
    end
  end

  wbpc_over u_bar_over (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_f2),
    .in_ready  (o1_ready),
    .in_bg     (color_background),
    .in_fg     (f2.fg),
    .in_aux    (f2.aux),
    .out_valid (o1_valid),
    .out_ready (o2_ready),
    .out_pix   (o1_pix),
    .out_aux   (o1_aux)
  );

  assign o2_fg = o1_aux ? color_playhead : argb_t'('0);

  wbpc_over u_head_over (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (o1_valid),
    .in_ready  (o2_ready),
    .in_bg     (o1_pix),
    .in_fg     (o2_fg),
    .in_aux    (1'b0),
    .out_valid (o2_valid),
    .out_ready (!pixel_stall),
    .out_pix   (o2_pix),
    .out_aux   ()
  );

  assign pixel_valid = o2_valid;
  assign pixel = o2_pix;

endmodule

// ===== sim/tb_waveform_bar_pixel_compositor.sv =====
module tb_waveform_bar_pixel_compositor;
  import wbpc_pkg::*;

  localparam int unsigned OPAQUE = 32'(CHAN_MAX);
  localparam int unsigned FULL_SCALE = 1 << LEVEL_FRAC_BITS;
  localparam int unsigned REG_COUNT = 5;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned DRAIN_SLACK = 40;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [LEVEL_W-1:0] level;
    logic               played;
    logic               on_playhead;
  } pix_req_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               item_valid;
  logic               item_stall;
  logic [ROW_W-1:0]   row;
  logic [LEVEL_W-1:0] level;
  logic               played;
  logic               on_playhead;
  logic               pixel_valid;
  logic               pixel_stall = 1'b0;
  logic [31:0]        pixel;

  logic [ROW_W-1:0] rows_setting;
  logic [31:0]      bg_colour;
  logic [31:0]      unplayed_colour;
  logic [31:0]      played_colour;
  logic [31:0]      head_colour;

  logic [31:0]  expected_pixels[$];
  logic [31:0]  wanted_pixel;
  int unsigned  fail_count = 0;
  int unsigned  pixels_seen = 0;
  int unsigned  cycles = 0;
  int unsigned  burst_left = 0;
  bit           gaps_on = 1'b1;

  int unsigned  hold_ticket = 0;
  int unsigned  hold_seen = 0;
  int unsigned  hold_left = 0;
  stall_mode_t  stall_mode = STALL_NONE;
  int unsigned  mode_left = 0;

  waveform_bar_pixel_compositor dut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycles,
               expected_pixels.size());
      $display("** waveform_bar_pixel_compositor: FAILED **");
      $finish;
    end
  end

  // The long hold-off is counted here; otherwise the stall pattern changes mode now and then.
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      pixel_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pixel_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:     pixel_stall <= 1'b0;
        STALL_LIGHT:    pixel_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    pixel_stall <= ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: pixel_stall <= (cycles % 7 < 3);
        default:        pixel_stall <= 1'b0;
      endcase
    end
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    if (!rst && pixel_valid && !pixel_stall) begin
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        note_failure($sformatf("unexpected pixel transfer %h", pixel));
      end else begin
        wanted_pixel = expected_pixels.pop_front();
        if (pixel !== wanted_pixel)
          note_failure($sformatf("pixel %0d: expected %h, got %h", pixels_seen,
                                 wanted_pixel, pixel));
      end
    end
  end

  function automatic logic [31:0] blend_over(input logic [31:0] under,
                                             input logic [31:0] top);
    int unsigned fa, ba, oa, fc, bc, v, ch;
    logic [31:0] res;
    fa = 32'(top[31:24]);
    ba = 32'(under[31:24]);
    if (fa == OPAQUE) return top;
    if (fa == 0) return under;
    oa = fa + (ba * (OPAQUE - fa)) / OPAQUE;
    if (oa > OPAQUE) oa = OPAQUE;
    res[31:24] = oa[7:0];
    for (ch = 0; ch < 3; ch++) begin
      fc = 32'(top[ch*8 +: 8]);
      bc = 32'(under[ch*8 +: 8]);
      v = (fc * fa + (bc * ba * (OPAQUE - fa)) / OPAQUE) / oa;
      if (v > OPAQUE) v = OPAQUE;
      res[ch*8 +: 8] = v[7:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] composite_pixel(input pix_req_t r);
    int unsigned rows, lvl, half, bar, y;
    logic [31:0] px;
    rows = 32'(rows_setting);
    if (rows > MAX_ROWS) rows = MAX_ROWS;
    lvl = 32'(r.level);
    if (lvl > FULL_SCALE) lvl = FULL_SCALE;
    half = rows / 2;
    bar = (lvl * half) >> LEVEL_FRAC_BITS;
    y = 32'(r.row);
    px = bg_colour;
    if (y < rows) begin
      if (y + bar >= half && y < half + bar)
        px = blend_over(px, r.played ? played_colour : unplayed_colour);
      if (r.on_playhead) px = blend_over(px, head_colour);
    end
    return px;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_STRIP_ROWS:       rows_setting = data[ROW_W-1:0];
      CFG_COLOR_BACKGROUND: bg_colour = data;
      CFG_COLOR_UNPLAYED:   unplayed_colour = data;
      CFG_COLOR_PLAYED:     played_colour = data;
      CFG_COLOR_PLAYHEAD:   head_colour = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel_request(input pix_req_t r);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    item_valid <= 1'b1;
    row <= r.row;
    level <= r.level;
    played <= r.played;
    on_playhead <= r.on_playhead;
    do @(posedge clk); while (item_stall);
    expected_pixels.push_back(composite_pixel(r));
  endtask

  task automatic send(input int unsigned y, input int unsigned lvl, input bit pl,
                      input bit hd);
    pix_req_t r;
    r.row = ROW_W'(y);
    r.level = LEVEL_W'(lvl);
    r.played = pl;
    r.on_playhead = hd;
    send_pixel_request(r);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  function automatic logic [31:0] random_colour();
    logic [7:0] alpha;
    case ($urandom_range(0, 5))
      0:       alpha = 8'h00;
      1:       alpha = CHAN_MAX;
      2:       alpha = 8'h01;
      3:       alpha = CHAN_MAX - 8'h01;
      default: alpha = 8'($urandom);
    endcase
    return {alpha, 24'($urandom)};
  endfunction

  function automatic logic [31:0] random_strip_rows();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2:       return 2047;
      3:       return $urandom_range(2, 64);
      4:       return $urandom;
      default: return $urandom_range(1, 2047);
    endcase
  endfunction

  function automatic pix_req_t random_request();
    pix_req_t r;
    int unsigned rows, lvl, half, bar;
    rows = 32'(rows_setting);
    case ($urandom_range(0, 9))
      0:       r.level = LEVEL_W'($urandom);
      1:       r.level = LEVEL_W'(FULL_SCALE);
      2:       r.level = '0;
      default: r.level = LEVEL_W'($urandom_range(0, FULL_SCALE));
    endcase
    lvl = 32'(r.level);
    if (lvl > FULL_SCALE) lvl = FULL_SCALE;
    half = rows / 2;
    bar = (lvl * half) >> LEVEL_FRAC_BITS;
    case ($urandom_range(0, 9))
      0:       r.row = ROW_W'($urandom);
      1:       r.row = ROW_W'(half + bar - $urandom_range(0, 1));
      2:       r.row = ROW_W'(half - bar - $urandom_range(0, 1));
      3:       r.row = ROW_W'(rows - $urandom_range(0, 1));
      default: r.row = (rows == 0) ? ROW_W'(0) : ROW_W'($urandom_range(0, rows - 1));
    endcase
    r.played = 1'($urandom);
    r.on_playhead = ($urandom_range(0, 3) == 0);
    return r;
  endfunction

  task automatic test_reset_defaults();
    send(0, FULL_SCALE, 1'b1, 1'b1);
    send(19, 0, 1'b0, 1'b0);
    wait_drained();
  endtask

  task automatic test_bar_edges();
    write_reg(CFG_STRIP_ROWS, 32'hFFFF_F800 | 32'd20);
    write_reg(CFG_COLOR_BACKGROUND, 32'h80_102030);
    write_reg(CFG_COLOR_UNPLAYED, 32'hFF_00FF00);
    write_reg(CFG_COLOR_PLAYED, 32'h40_FF0000);
    write_reg(CFG_COLOR_PLAYHEAD, 32'hC0_0000FF);
    send(4, FULL_SCALE / 2, 1'b1, 1'b0);
    send(5, FULL_SCALE / 2, 1'b1, 1'b0);
    send(14, FULL_SCALE / 2, 1'b0, 1'b1);
    send(15, FULL_SCALE / 2, 1'b0, 1'b0);
    send(0, FULL_SCALE, 1'b1, 1'b1);
    send(19, 131071, 1'b0, 1'b0);
    send(20, FULL_SCALE, 1'b1, 1'b1);
    send(2047, FULL_SCALE, 1'b0, 1'b1);
    send(10, 0, 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_alpha_extremes();
    write_reg(CFG_COLOR_BACKGROUND, 32'h00_FFFFFF);
    write_reg(CFG_COLOR_PLAYED, 32'hFFFF_FFFF);
    write_reg(CFG_COLOR_UNPLAYED, 32'h00_ABCDEF);
    write_reg(CFG_COLOR_PLAYHEAD, 32'h01_123456);
    send(10, FULL_SCALE, 1'b1, 1'b1);
    send(10, FULL_SCALE, 1'b0, 1'b1);
    wait_drained();
    write_reg(CFG_COLOR_BACKGROUND, 32'hFFFF_FFFF);
    write_reg(CFG_COLOR_PLAYED, 32'h7F_000000);
    write_reg(CFG_COLOR_PLAYHEAD, 32'hFE_FFFFFF);
    send(10, FULL_SCALE, 1'b1, 1'b1);
    send(3, 0, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_strip_sizes();
    write_reg(CFG_STRIP_ROWS, 32'd0);
    send(0, FULL_SCALE, 1'b1, 1'b1);
    wait_drained();
    write_reg(CFG_STRIP_ROWS, 32'd1);
    send(0, FULL_SCALE, 1'b1, 1'b1);
    send(1, FULL_SCALE, 1'b0, 1'b1);
    wait_drained();
    write_reg(CFG_STRIP_ROWS, 32'd2047);
    send(2046, FULL_SCALE, 1'b1, 1'b0);
    send(1023, 1, 1'b0, 1'b1);
    send(0, FULL_SCALE - 1, 1'b1, 1'b0);
    wait_drained();
  endtask

  task automatic test_unlisted_registers();
    int unsigned idx;
    for (idx = REG_COUNT; idx < 8; idx++) write_reg(3'(idx), $urandom);
    send(1000, FULL_SCALE, 1'b1, 1'b1);
    send(3, FULL_SCALE / 4, 1'b0, 1'b0);
    wait_drained();
  endtask

  // The receiver holds off while items keep coming, so the block fills and stalls its input.
  task automatic test_output_holdoff();
    int unsigned n;
    write_reg(CFG_STRIP_ROWS, 32'd64);
    gaps_on = 1'b0;
    hold_ticket <= hold_ticket + 1;
    for (n = 0; n < 80; n++) send_pixel_request(random_request());
    wait_drained();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned sent, phase_len, n, idx;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      for (idx = 0; idx < REG_COUNT; idx++) begin
        if ($urandom_range(0, 1) == 0) begin
          if (idx == CFG_STRIP_ROWS) write_reg(3'(idx), random_strip_rows());
          else write_reg(3'(idx), random_colour());
        end
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(30, 120);
      for (n = 0; n < phase_len; n++) begin
        send_pixel_request(random_request());
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
      sent += phase_len;
      wait_drained();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_valid = 1'b0;
    row = '0;
    level = '0;
    played = 1'b0;
    on_playhead = 1'b0;
    rows_setting = 11'd20;
    bg_colour = '0;
    unplayed_colour = '0;
    played_colour = '0;
    head_colour = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_bar_edges();
    test_alpha_extremes();
    test_strip_sizes();
    test_unlisted_registers();
    test_output_holdoff();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_SLACK) @(posedge clk);
    if (fail_count == 0 && expected_pixels.size() == 0) begin
      $display("** waveform_bar_pixel_compositor: PASSED **");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("** waveform_bar_pixel_compositor: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/wbpc_pkg.sv
design/wbpc_over.sv
design/waveform_bar_pixel_compositor.sv
sim/tb_waveform_bar_pixel_compositor.sv
